[src/tpr_pkg.sv]
// Shared types and constants for the period-measuring tachometer.
// No dependencies; imported by every module of the block.
`default_nettype none
package tpr_pkg;

   localparam int unsigned RPM_NUMERATOR = 60000;
   localparam int unsigned RPM_MAX       = 60000;
   localparam int unsigned RPM_W         = 16;
   localparam int unsigned TIMEOUT_W     = 16;
   localparam int unsigned CPR_W         = 5;
   localparam int unsigned CSR_IDX_W     = 1;
   localparam int unsigned CSR_DATA_W    = 16;
   localparam int unsigned REQ_DATA_W    = 8;
   localparam int unsigned RSP_DATA_W    = 40;
   localparam int unsigned EVENT_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_STOP_TIMEOUT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANGES_ROT  = 1'b1;

   localparam logic [TIMEOUT_W-1:0] STOP_TIMEOUT_RST = 16'd1500;
   localparam logic [CPR_W-1:0]     CPR_RST          = 5'd4;

   localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
   localparam logic [EVENT_W-1:0] EV_STARTED = 2'd1;
   localparam logic [EVENT_W-1:0] EV_STOPPED = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV_RPM,
      ST_MEAN_START,
      ST_DIV_MEAN,
      ST_OUT
   } state_type;

endpackage
`default_nettype wire

[src/tpr_serial_mul.sv]
// Bit-serial shift-add multiplier: one multiplier bit per cycle.
// Depends on tpr_pkg for the multiplier width.
`default_nettype none
module tpr_serial_mul #(
   parameter int unsigned B_W = 16
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire [tpr_pkg::CPR_W-1:0]       a,
   input  wire [B_W-1:0]                  b,
   output logic [B_W+tpr_pkg::CPR_W-1:0]  product,
   output logic                           done
);
   import tpr_pkg::*;

   localparam int unsigned P_W   = B_W + CPR_W;
   localparam int unsigned CNT_W = $clog2(CPR_W + 1);

   logic [CPR_W-1:0] a_ff, a_in;
   logic [P_W-1:0]   b_ff, b_in;
   logic [P_W-1:0]   acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = P_W'(b);
         acc_in  = '0;
         cnt_in  = CNT_W'(CPR_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (a_ff[0]) begin
            acc_in = acc_ff + b_ff;
         end
         a_in   = a_ff >> 1;
         b_in   = b_ff << 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      acc_ff <= acc_in;
   end

   assign product = acc_ff;
   assign done    = done_ff;

endmodule
`default_nettype wire

[src/tpr_serial_div.sv]
// Restoring divider, one quotient bit per cycle, shared by rpm and mean.
// Depends on tpr_pkg (imported for consistency with the block).
`default_nettype none
module tpr_serial_div #(
   parameter int unsigned NUM_W = 19,
   parameter int unsigned DEN_W = 21
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               start,
   input  wire [NUM_W-1:0]   numer,
   input  wire [DEN_W-1:0]   denom,
   output logic [NUM_W-1:0]  quotient,
   output logic              done
);
   import tpr_pkg::*;

   localparam int unsigned REM_W = DEN_W + 1;
   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] shifted;
   logic [REM_W-1:0] diff;
   logic             ge;

   assign shifted = {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
   assign ge      = shifted >= {1'b0, den_ff};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff : shifted;
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quotient = num_ff;
   assign done     = done_ff;

endmodule
`default_nettype wire

[src/tachometer_period_rpm_unit.sv]
// Period-measuring tachometer: tick sequencer, rpm window and result register.
// Depends on tpr_pkg, tpr_serial_mul and tpr_serial_div.
// A tick without a speed update goes from ST_IDLE to ST_OUT, which registers the result and raises
// rsp_tvalid. A speed update runs ST_MUL, ST_DIV_RPM, ST_MEAN_START and ST_DIV_MEAN first: a
// multiply and two divisions with an S-bit quotient (S = window sum width, 19 by default).
// The next tick is taken only once ST_OUT has returned to ST_IDLE; a second
// result held back by rsp stalls req. Synchronous reset returns all registers but rsp_data to reset values.
`default_nettype none
module tachometer_period_rpm_unit #(
   parameter int unsigned WINDOW     = 5,
   parameter int unsigned TIME_WIDTH = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [tpr_pkg::REQ_DATA_W-1:0]     req_tdata,   // [0] pin_level
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [tpr_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // [15:0] rpm_now, [31:16] rpm_mean,
                                                          // [32] moving, [34:33] event_code
   input  wire                               csr_wen,
   input  wire [tpr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire [tpr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tpr_pkg::*;

   localparam int unsigned SUM_W  = $clog2(WINDOW * RPM_MAX + 1);
   localparam int unsigned DEN_W  = TIME_WIDTH + CPR_W;
   localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int unsigned CMP_W  = (TIME_WIDTH > TIMEOUT_W) ? TIME_WIDTH : TIMEOUT_W;

   state_type              state_ff, state_in;
   logic [TIMEOUT_W-1:0]   timeout_ff, timeout_in;
   logic [CPR_W-1:0]       cpr_ff, cpr_in;
   logic                   prev_ff, prev_in;
   logic [TIME_WIDTH-1:0]  elapsed_ff, elapsed_in;
   logic                   rot_ff, rot_in;
   logic [RPM_W-1:0]       rpm_ff, rpm_in;
   logic [RPM_W-1:0]       win_ff [WINDOW];
   logic [RPM_W-1:0]       win_in [WINDOW];
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [RPM_W-1:0]       mean_ff, mean_in;
   logic [EVENT_W-1:0]     event_ff, event_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic                   req_xfer;
   logic                   level;
   logic                   change;
   logic [TIME_WIDTH-1:0]  elapsed_inc;
   logic                   timed_out;
   logic [CPR_W-1:0]       cpr_eff;
   logic                   mul_start;
   logic                   mul_done;
   logic [DEN_W-1:0]       mul_product;
   logic                   div_start;
   logic                   div_done;
   logic [SUM_W-1:0]       div_numer;
   logic [DEN_W-1:0]       div_denom;
   logic [SUM_W-1:0]       div_quot;
   logic [RPM_W-1:0]       rpm_new;

   assign req_tready  = (state_ff == ST_IDLE);
   assign req_xfer    = req_tvalid && req_tready;
   assign level       = req_tdata[0];
   assign change      = level != prev_ff;
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign timed_out   = CMP_W'(elapsed_inc) >= CMP_W'(timeout_ff);
   assign cpr_eff     = (cpr_ff == '0) ? CPR_W'(1) : cpr_ff;
   assign rpm_new     = div_quot[RPM_W-1:0];

   tpr_serial_mul #(
      .B_W(TIME_WIDTH)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (cpr_eff),
      .b      (elapsed_inc),
      .product(mul_product),
      .done   (mul_done)
   );

   tpr_serial_div #(
      .NUM_W(SUM_W),
      .DEN_W(DEN_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .numer   (div_numer),
      .denom   (div_denom),
      .quotient(div_quot),
      .done    (div_done)
   );

   always_comb begin
      state_in     = state_ff;
      timeout_in   = timeout_ff;
      cpr_in       = cpr_ff;
      prev_in      = prev_ff;
      elapsed_in   = elapsed_ff;
      rot_in       = rot_ff;
      rpm_in       = rpm_ff;
      win_in       = win_ff;
      slot_in      = slot_ff;
      sum_in       = sum_ff;
      mean_in      = mean_ff;
      event_in     = event_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      div_start    = 1'b0;
      div_numer    = SUM_W'(RPM_NUMERATOR);
      div_denom    = mul_product;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wen) begin
         case (csr_index)
            CSR_STOP_TIMEOUT: timeout_in = csr_wdata;
            CSR_CHANGES_ROT:  cpr_in     = csr_wdata[CPR_W-1:0];
            default:          ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               event_in   = EV_NONE;
               elapsed_in = elapsed_inc;
               state_in   = ST_OUT;
               if (change) begin
                  rot_in     = 1'b1;
                  elapsed_in = '0;
                  prev_in    = level;
                  if (rot_ff) begin
                     mul_start = 1'b1;
                     state_in  = ST_MUL;
                  end else begin
                     event_in = EV_STARTED;
                  end
               end else if (rot_ff && timed_out) begin
                  event_in = EV_STOPPED;
                  rot_in   = 1'b0;
                  rpm_in   = '0;
                  for (int i = 0; i < WINDOW; i++) begin
                     win_in[i] = '0;
                  end
                  slot_in = '0;
                  sum_in  = '0;
                  mean_in = '0;
               end
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               div_start = 1'b1;
               state_in  = ST_DIV_RPM;
            end
         end
         ST_DIV_RPM: begin
            if (div_done) begin
               rpm_in          = rpm_new;
               win_in[slot_ff] = rpm_new;
               sum_in          = sum_ff - SUM_W'(win_ff[slot_ff]) + SUM_W'(rpm_new);
               slot_in         = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
               state_in        = ST_MEAN_START;
            end
         end
         ST_MEAN_START: begin
            div_numer = sum_ff;
            div_denom = DEN_W'(WINDOW);
            div_start = 1'b1;
            state_in  = ST_DIV_MEAN;
         end
         ST_DIV_MEAN: begin
            if (div_done) begin
               mean_in  = div_quot[RPM_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, event_ff, rot_ff, mean_ff, rpm_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         timeout_ff   <= STOP_TIMEOUT_RST;
         cpr_ff       <= CPR_RST;
         prev_ff      <= 1'b0;
         elapsed_ff   <= '0;
         rot_ff       <= 1'b0;
         rpm_ff       <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            win_ff[i] <= '0;
         end
         slot_ff      <= '0;
         sum_ff       <= '0;
         mean_ff      <= '0;
         event_ff     <= EV_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         timeout_ff   <= timeout_in;
         cpr_ff       <= cpr_in;
         prev_ff      <= prev_in;
         elapsed_ff   <= elapsed_in;
         rot_ff       <= rot_in;
         rpm_ff       <= rpm_in;
         win_ff       <= win_in;
         slot_ff      <= slot_in;
         sum_ff       <= sum_in;
         mean_ff      <= mean_in;
         event_ff     <= event_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(WINDOW - 1))
      else $error("window slot out of range");

   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[34:33] == EV_STOPPED) |->
         !rsp_tdata[32] && (rsp_tdata[15:0] == '0) && (rsp_tdata[31:16] == '0))
      else $error("stop transfer with live speed");

   a_start_moving: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[34:33] == EV_STARTED) |-> rsp_tdata[32])
      else $error("start transfer without moving flag");

   a_mean_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[31:16] <= 16'(RPM_MAX)))
      else $error("mean above full scale");

   a_div_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_RPM) || (state_ff == ST_DIV_MEAN))
      else $error("divider finished outside a divide state");

endmodule
`default_nettype wire
